FILE: hw/rtl/mlpt_pkg.sv
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared types, constants and helper functions of the multilevel page table.
// ----------------------------------------------------------------------------
package mlpt_pkg;

  localparam int ADDR_BITS      = 32;
  localparam int MAX_LEVELS     = 4;
  localparam int MAX_LEVEL_BITS = 6;
  localparam int NODE_COUNT     = 64;
  localparam int FRAME_BITS     = 20;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SLOT_W     = NODE_W + MAX_LEVEL_BITS;
  localparam int ENTRY_W    = FRAME_BITS + 1;
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LB_W       = $clog2(MAX_LEVEL_BITS + 1);
  localparam int CUM_W      = $clog2(MAX_LEVELS * MAX_LEVEL_BITS + 1);
  localparam int SH_W       = $clog2(ADDR_BITS + 1);
  localparam int CALC_W     = (CUM_W > SH_W) ? CUM_W : SH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_COUNT  = 3'd0,
    CFG_BITS_FIRST   = 3'd1,
    CFG_BITS_SECOND  = 3'd2,
    CFG_BITS_THIRD   = 3'd3,
    CFG_BITS_FOURTH  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    WK_CLEAR,
    WK_IDLE,
    WK_READ,
    WK_EVAL,
    WK_DONE
  } walk_state_e;

  typedef logic [LB_W-1:0] lbits_t;

  typedef struct packed {
    logic [LVL_W-1:0]                last_lvl;
    logic [MAX_LEVELS-1:0][LB_W-1:0] bits;
  } cfg_t;

  typedef struct packed {
    status_e                 status;
    logic [FRAME_BITS-1:0]   frame;
    logic [ADDR_BITS-1:0]    addr;
  } result_t;

  function automatic lbits_t clamp_bits(logic [CFG_DATA_W-1:0] raw);
    lbits_t res;
    if (raw == '0) begin
      res = LB_W'(1);
    end else if (int'(raw) > MAX_LEVEL_BITS) begin
      res = LB_W'(MAX_LEVEL_BITS);
    end else begin
      res = LB_W'(raw);
    end
    return res;
  endfunction

  function automatic logic [LVL_W-1:0] clamp_last(logic [CFG_DATA_W-1:0] raw);
    logic [LVL_W-1:0] res;
    if (raw == '0) begin
      res = '0;
    end else if (int'(raw) > MAX_LEVELS) begin
      res = LVL_W'(MAX_LEVELS - 1);
    end else begin
      res = LVL_W'(int'(raw) - 1);
    end
    return res;
  endfunction

  function automatic logic [ADDR_BITS-1:0] offset_mask(logic [CUM_W-1:0] cum);
    logic [ADDR_BITS-1:0] res;
    if (CALC_W'(cum) >= CALC_W'(ADDR_BITS)) begin
      res = '0;
    end else begin
      res = {ADDR_BITS{1'b1}} >> cum;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/multilevel_page_table_unit.sv
// ----------------------------------------------------------------------------
// multilevel_page_table_unit
// Multilevel page table with insert and lookup over a 32-bit address.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry store clear before it takes its
// first transfer; configuration writes are taken during that time. An item
// then visits L levels, where L is at most the level count after it is clamped
// to one through four, and each level passes through a read state, which reads
// the single-port entry store, and an evaluate state, which evaluates the entry
// and, on an insert, may write the store. The reset setting is three levels.
// The result sits in an output register, so the next item may be accepted
// while a result still waits to be taken.
module multilevel_page_table_unit
  import mlpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [ADDR_BITS-1:0]  virtual_address_i,
  input  logic [FRAME_BITS-1:0] frame_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [FRAME_BITS-1:0] frame_out_o,
  output logic [ADDR_BITS-1:0]  page_offset_o
);

  logic [CFG_DATA_W-1:0]                    level_count_q;
  logic [MAX_LEVELS-1:0][CFG_DATA_W-1:0]    level_bits_q;
  cfg_t                                     cfg;
  logic [CUM_W-1:0]                         cum_total;
  logic                                     res_valid, res_ready;
  result_t                                  res;
  logic                                     out_valid_q;
  logic [1:0]                               status_q;
  logic [FRAME_BITS-1:0]                    frame_q;
  logic [ADDR_BITS-1:0]                     offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= CFG_DATA_W'(3);
      level_bits_q  <= {MAX_LEVELS{CFG_DATA_W'(6)}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEVEL_COUNT: level_count_q   <= cfg_data_i;
        CFG_BITS_FIRST:  level_bits_q[0] <= cfg_data_i;
        CFG_BITS_SECOND: level_bits_q[1] <= cfg_data_i;
        CFG_BITS_THIRD:  level_bits_q[2] <= cfg_data_i;
        CFG_BITS_FOURTH: level_bits_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.last_lvl = clamp_last(level_count_q);
    cum_total    = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      cfg.bits[i] = clamp_bits(level_bits_q[i]);
      if (i <= int'(cfg.last_lvl)) begin
        cum_total = cum_total + CUM_W'(cfg.bits[i]);
      end
    end
  end

  mlpt_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_op_i    (opcode_e'(opcode_i)),
    .req_addr_i  (virtual_address_i),
    .req_frame_i (frame_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q <= res.status;
      frame_q  <= res.frame;
      offset_q <= res.addr & offset_mask(cum_total);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign frame_out_o   = frame_q;
  assign page_offset_o = offset_q;

endmodule

FILE: hw/rtl/mlpt_index_unit.sv
// ----------------------------------------------------------------------------
// mlpt_index_unit
// Shared shift and mask unit that extracts one level's index from an address.
// ----------------------------------------------------------------------------
module mlpt_index_unit
  import mlpt_pkg::*;
(
  input  logic [ADDR_BITS-1:0]      addr_i,
  input  logic [CUM_W-1:0]          cum_i,
  input  lbits_t                    bits_i,
  output logic [MAX_LEVEL_BITS-1:0] idx_o
);

  logic [CALC_W-1:0]         shamt;
  logic [ADDR_BITS-1:0]      shifted;
  logic [MAX_LEVEL_BITS-1:0] mask;

  always_comb begin
    shamt   = CALC_W'(ADDR_BITS) - CALC_W'(cum_i);
    shifted = addr_i >> shamt;
    for (int i = 0; i < MAX_LEVEL_BITS; i++) begin
      mask[i] = (i < int'(bits_i));
    end
    if (CALC_W'(cum_i) > CALC_W'(ADDR_BITS)) begin
      idx_o = '0;
    end else begin
      idx_o = shifted[MAX_LEVEL_BITS-1:0] & mask;
    end
  end

endmodule

FILE: hw/rtl/mlpt_walker.sv
// ----------------------------------------------------------------------------
// mlpt_walker
// Entry store and the sequencer that walks it one level at a time.
// ----------------------------------------------------------------------------
module mlpt_walker
  import mlpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  opcode_e               req_op_i,
  input  logic [ADDR_BITS-1:0]  req_addr_i,
  input  logic [FRAME_BITS-1:0] req_frame_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output result_t               res_o
);

  logic [ENTRY_W-1:0] mem [2**SLOT_W];

  walk_state_e state_q, state_d;
  logic [SLOT_W-1:0]     clr_q, clr_d;
  logic [FREE_W-1:0]     free_q, free_d;
  logic [NODE_W-1:0]     node_q, node_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [CUM_W-1:0]      cum_q, cum_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  opcode_e               op_q, op_d;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic [FRAME_BITS-1:0] fin_q, fin_d;
  status_e               status_q, status_d;
  logic [FRAME_BITS-1:0] fout_q, fout_d;
  logic [ENTRY_W-1:0]    rdata_q;

  logic                      mem_we, mem_re;
  logic [SLOT_W-1:0]         mem_waddr;
  logic [ENTRY_W-1:0]        mem_wdata;
  logic [CUM_W-1:0]          cum_cur;
  logic [MAX_LEVEL_BITS-1:0] idx;
  logic                      last_lvl, entry_valid, child_ok, eval_done;
  logic [FRAME_BITS-1:0]     entry_pay;

  assign cum_cur     = cum_q + CUM_W'(cfg_i.bits[lvl_q]);
  assign last_lvl    = (lvl_q == cfg_i.last_lvl);
  assign entry_valid = rdata_q[FRAME_BITS];
  assign entry_pay   = rdata_q[FRAME_BITS-1:0];
  assign child_ok    = entry_valid && (entry_pay < FRAME_BITS'(NODE_COUNT));
  assign eval_done   = last_lvl || !child_ok && (op_q == OP_LOOKUP
                       || free_q >= FREE_W'(NODE_COUNT));

  mlpt_index_unit u_index (
    .addr_i (addr_q),
    .cum_i  (cum_cur),
    .bits_i (cfg_i.bits[lvl_q]),
    .idx_o  (idx)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      WK_CLEAR: begin
        if (clr_q == '1) begin
          state_d = WK_IDLE;
        end
      end
      WK_IDLE: begin
        if (req_valid_i) begin
          state_d = WK_READ;
        end
      end
      WK_READ: begin
        state_d = WK_EVAL;
      end
      WK_EVAL: begin
        state_d = eval_done ? WK_DONE : WK_READ;
      end
      WK_DONE: begin
        if (res_ready_i) begin
          state_d = WK_IDLE;
        end
      end
      default: begin
        state_d = WK_IDLE;
      end
    endcase
  end

  always_comb begin
    clr_d     = clr_q;
    free_d    = free_q;
    node_d    = node_q;
    lvl_d     = lvl_q;
    cum_d     = cum_q;
    slot_d    = slot_q;
    op_d      = op_q;
    addr_d    = addr_q;
    fin_d     = fin_q;
    status_d  = status_q;
    fout_d    = fout_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = '0;
    unique case (state_q)
      WK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + SLOT_W'(1);
      end
      WK_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_op_i;
          addr_d   = req_addr_i;
          fin_d    = req_frame_i;
          node_d   = '0;
          lvl_d    = '0;
          cum_d    = '0;
          status_d = STATUS_OK;
          fout_d   = '0;
        end
      end
      WK_READ: begin
        mem_re = 1'b1;
        slot_d = {node_q, idx};
        cum_d  = cum_cur;
      end
      WK_EVAL: begin
        if (last_lvl) begin
          if (op_q == OP_INSERT) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, fin_q};
          end else if (entry_valid) begin
            fout_d = entry_pay;
          end else begin
            status_d = STATUS_MISS;
          end
        end else if (child_ok) begin
          node_d = NODE_W'(entry_pay);
          lvl_d  = lvl_q + LVL_W'(1);
        end else if (op_q == OP_LOOKUP) begin
          status_d = STATUS_MISS;
        end else if (free_q < FREE_W'(NODE_COUNT)) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, FRAME_BITS'(free_q)};
          node_d    = NODE_W'(free_q);
          free_d    = free_q + FREE_W'(1);
          lvl_d     = lvl_q + LVL_W'(1);
        end else begin
          status_d = STATUS_FULL;
        end
      end
      WK_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign req_ready_o = (state_q == WK_IDLE);
  assign res_valid_o = (state_q == WK_DONE);
  assign res_o       = '{status: status_q, frame: fout_q, addr: addr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WK_CLEAR;
      clr_q   <= '0;
      free_q  <= FREE_W'(1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    lvl_q    <= lvl_d;
    cum_q    <= cum_d;
    slot_q   <= slot_d;
    op_q     <= op_d;
    addr_q   <= addr_d;
    fin_q    <= fin_d;
    status_q <= status_d;
    fout_q   <= fout_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[slot_d];
    end
  end

endmodule

FILE: hw/rtl/mlpt_checker.sv
// ----------------------------------------------------------------------------
// mlpt_checker
// Port-level checks of the page table unit, bound to the top level.
// ----------------------------------------------------------------------------
module mlpt_checker
  import mlpt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [1:0]            status_o,
  input logic [FRAME_BITS-1:0] frame_out_o,
  input logic [ADDR_BITS-1:0]  page_offset_o
);

  // A held result keeps its payload until the transfer completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(frame_out_o) && $stable(page_offset_o))
    else $error("held result changed before its transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STATUS_OK || status_o == STATUS_MISS
      || status_o == STATUS_FULL)
    else $error("undefined status code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> frame_out_o == '0)
    else $error("frame reported with a miss or full status");

  // The walk passes through read and evaluate states, so an accepted item blocks the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transfer");

endmodule

bind multilevel_page_table_unit mlpt_checker u_mlpt_checker (.*);

FILE: dv/multilevel_page_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_page_table_unit_tb
// Self-checking bench for the multilevel page table. A directed list of
// inserts and lookups runs first. Random traffic follows over several table
// settings, which include out-of-range register values. Every output transfer
// is held to a typed result or a model of the table walk. The random traffic
// also has stalls on both handshakes, one long output hold and one full drain.
// ----------------------------------------------------------------------------
module multilevel_page_table_unit_tb;
  import mlpt_pkg::*;

  localparam int CLOCK_LIMIT  = 250000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 2 * MAX_LEVELS + 12;
  localparam int SLOTS        = NODE_COUNT << MAX_LEVEL_BITS;
  localparam int NUM_ROWS     = 20;
  localparam int NUM_PHASES   = 8;
  localparam int KNOWN_MAX    = 48;

  typedef struct {
    opcode_e               op;
    logic [ADDR_BITS-1:0]  addr;
    logic [FRAME_BITS-1:0] frame;
    bit                    typed;
    result_t               res;
  } directed_row_t;

  typedef struct {
    logic [2:0]  levels;
    logic [2:0]  bits0;
    logic [2:0]  bits1;
    logic [2:0]  bits2;
    logic [2:0]  bits3;
    int unsigned send_idle;
    int unsigned recv_stall;
    int unsigned fresh_pct;
    int unsigned items;
    bit          drain;
    bit          hold;
  } phase_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_e              cfg_idx = CFG_LEVEL_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  opcode_e               opcode = OP_INSERT;
  logic [ADDR_BITS-1:0]  vaddr = '0;
  logic [FRAME_BITS-1:0] frame_in = '0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [1:0]            status;
  logic [FRAME_BITS-1:0] frame_out;
  logic [ADDR_BITS-1:0]  page_offset;

  logic [ENTRY_W-1:0]    entry_mem [SLOTS];
  logic [6:0]            free_node;
  logic [2:0]            levels_raw;
  logic [2:0]            bits_raw [MAX_LEVELS];

  result_t               pending_results [$];
  logic [ADDR_BITS-1:0]  known_addrs [$];
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  bit                    hold_req = 1'b0;
  int                    mismatches = 0;
  int                    cycle_count = 0;

  // Typed results assume three levels of six index bits each.
  directed_row_t walk_rows [NUM_ROWS] = '{
    '{OP_LOOKUP, 32'h0000_0000, 20'h00000, 1'b1, '{STATUS_MISS, 20'h00000, 32'h0000_0000}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 1'b1, '{STATUS_MISS, 20'h00000, 32'h0000_3FFF}},
    '{OP_INSERT, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, '{STATUS_OK, 20'h00000, 32'h0000_3FFF}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 1'b1, '{STATUS_OK, 20'hFFFFF, 32'h0000_3FFF}},
    '{OP_LOOKUP, 32'hFFFF_C000, 20'hFFFFF, 1'b1, '{STATUS_OK, 20'hFFFFF, 32'h0000_0000}},
    '{OP_INSERT, 32'h0000_0000, 20'h00000, 1'b1, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_LOOKUP, 32'h0000_0000, 20'h00000, 1'b1, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_INSERT, 32'hFFFF_0000, 20'h12345, 1'b1, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_LOOKUP, 32'hFFFF_0ABC, 20'h00000, 1'b1, '{STATUS_OK, 20'h12345, 32'h0000_0ABC}},
    '{OP_LOOKUP, 32'hFC00_0000, 20'h00000, 1'b1, '{STATUS_MISS, 20'h00000, 32'h0000_0000}},
    '{OP_INSERT, 32'hFFFF_FFFF, 20'h00001, 1'b1, '{STATUS_OK, 20'h00000, 32'h0000_3FFF}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 1'b1, '{STATUS_OK, 20'h00001, 32'h0000_3FFF}},
    '{OP_INSERT, 32'h0000_3FFF, 20'h00ABC, 1'b1, '{STATUS_OK, 20'h00000, 32'h0000_3FFF}},
    '{OP_LOOKUP, 32'h0000_0000, 20'h00000, 1'b1, '{STATUS_OK, 20'h00ABC, 32'h0000_0000}},
    '{OP_INSERT, 32'h8000_0000, 20'h5A5A5, 1'b0, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_LOOKUP, 32'h8000_1234, 20'h00000, 1'b0, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_INSERT, 32'h1234_5678, 20'hA5A5A, 1'b0, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_LOOKUP, 32'h1234_5678, 20'h00000, 1'b0, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_LOOKUP, 32'h1234_0000, 20'h00000, 1'b0, '{STATUS_OK, 20'h00000, 32'h0000_0000}},
    '{OP_LOOKUP, 32'hAAAA_AAAA, 20'h55555, 1'b0, '{STATUS_OK, 20'h00000, 32'h0000_0000}}
  };

  phase_t phase_tbl [NUM_PHASES] = '{
    '{3'd3, 3'd6, 3'd6, 3'd6, 3'd6,  0,  0, 15, 60, 1'b1, 1'b0},
    '{3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 83,  0, 20, 60, 1'b0, 1'b0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0,  0, 83, 20, 60, 1'b0, 1'b0},
    '{3'd1, 3'd6, 3'd6, 3'd6, 3'd6, 29, 29, 20, 60, 1'b0, 1'b0},
    '{3'd3, 3'd6, 3'd6, 3'd6, 3'd6,  0,  0, 15, 60, 1'b0, 1'b1},
    '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7,  0, 83, 60, 60, 1'b0, 1'b0},
    '{3'd2, 3'd3, 3'd5, 3'd2, 3'd4, 83,  0, 15, 60, 1'b0, 1'b0},
    '{3'd4, 3'd2, 3'd3, 3'd4, 3'd5, 29, 29, 15, 60, 1'b0, 1'b0}
  };

  multilevel_page_table_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .opcode_i          (opcode),
    .virtual_address_i (vaddr),
    .frame_in_i        (frame_in),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .frame_out_o       (frame_out),
    .page_offset_o     (page_offset)
  );

  always #5 clk_i = ~clk_i;

  function automatic int level_width(int lvl);
    int raw;
    raw = int'(bits_raw[lvl]);
    if (raw < 1) begin
      return 1;
    end else if (raw > MAX_LEVEL_BITS) begin
      return MAX_LEVEL_BITS;
    end
    return raw;
  endfunction

  function automatic int levels_in_use();
    int raw;
    raw = int'(levels_raw);
    if (raw < 1) begin
      return 1;
    end else if (raw > MAX_LEVELS) begin
      return MAX_LEVELS;
    end
    return raw;
  endfunction

  function automatic int total_index_bits();
    int sum;
    sum = 0;
    for (int lvl = 0; lvl < levels_in_use(); lvl++) begin
      sum += level_width(lvl);
    end
    return sum;
  endfunction

  function automatic logic [ADDR_BITS-1:0] offset_bits(int cum);
    return {ADDR_BITS{1'b1}} >> cum;
  endfunction

  function automatic result_t predict_walk(opcode_e op, logic [ADDR_BITS-1:0] va,
                                           logic [FRAME_BITS-1:0] fr);
    result_t            res;
    logic [ENTRY_W-1:0] ent;
    int                 levels;
    int                 width;
    int                 cum;
    int                 node;
    int                 slot;
    bit                 stop;
    levels = levels_in_use();
    res.status = STATUS_OK;
    res.frame = '0;
    node = 0;
    cum = 0;
    stop = 1'b0;
    for (int lvl = 0; lvl < levels && !stop; lvl++) begin
      width = level_width(lvl);
      cum += width;
      slot = (node << MAX_LEVEL_BITS)
             + int'((va >> (ADDR_BITS - cum)) & ((32'd1 << width) - 32'd1));
      ent = entry_mem[slot];
      if (lvl == levels - 1) begin
        if (op == OP_INSERT) begin
          entry_mem[slot] = {1'b1, fr};
        end else if (ent[FRAME_BITS]) begin
          res.frame = ent[FRAME_BITS-1:0];
        end else begin
          res.status = STATUS_MISS;
        end
      end else if (ent[FRAME_BITS] && ent[FRAME_BITS-1:0] < NODE_COUNT) begin
        node = int'(ent[FRAME_BITS-1:0]);
      end else if (op == OP_LOOKUP) begin
        res.status = STATUS_MISS;
        stop = 1'b1;
      end else if (free_node < NODE_COUNT) begin
        node = int'(free_node);
        free_node = free_node + 7'd1;
        entry_mem[slot] = {1'b1, FRAME_BITS'(node)};
      end else begin
        res.status = STATUS_FULL;
        stop = 1'b1;
      end
    end
    res.addr = va & offset_bits(total_index_bits());
    return res;
  endfunction

  // Addresses along paths that were inserted before, so that lookups hit and
  // inserts share inner nodes, or, at a rate of fresh_pct percent, fresh ones.
  function automatic logic [ADDR_BITS-1:0] pick_address(int unsigned fresh_pct);
    logic [ADDR_BITS-1:0] va;
    logic [ADDR_BITS-1:0] keep;
    logic [ADDR_BITS-1:0] leaf;
    int                   total;
    total = total_index_bits();
    keep = offset_bits(total);
    leaf = offset_bits(total - level_width(levels_in_use() - 1)) & ~keep;
    if (known_addrs.size() == 0 || $urandom_range(99) < fresh_pct) begin
      va = $urandom;
    end else begin
      va = known_addrs[$urandom_range(known_addrs.size() - 1)];
      va = (va & ~keep) | ($urandom & keep);
      if ($urandom_range(2) == 0) begin
        va = (va & ~leaf) | ($urandom & leaf);
      end
    end
    return va;
  endfunction

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_LEVEL_COUNT: levels_raw = val;
      CFG_BITS_FIRST:  bits_raw[0] = val;
      CFG_BITS_SECOND: bits_raw[1] = val;
      CFG_BITS_THIRD:  bits_raw[2] = val;
      CFG_BITS_FOURTH: bits_raw[3] = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(phase_t ph);
    write_register(CFG_LEVEL_COUNT, ph.levels);
    write_register(CFG_BITS_FIRST, ph.bits0);
    write_register(CFG_BITS_SECOND, ph.bits1);
    write_register(CFG_BITS_THIRD, ph.bits2);
    write_register(CFG_BITS_FOURTH, ph.bits3);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(opcode_e op, logic [ADDR_BITS-1:0] va,
                              logic [FRAME_BITS-1:0] fr, bit typed, result_t typed_res);
    result_t walk_res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    opcode <= op;
    vaddr <= va;
    frame_in <= fr;
    do @(posedge clk_i); while (!in_ready);
    walk_res = predict_walk(op, va, fr);
    pending_results.push_back(typed ? typed_res : walk_res);
    if (op == OP_INSERT) begin
      if (known_addrs.size() < KNOWN_MAX) begin
        known_addrs.push_back(va);
      end else begin
        known_addrs[$urandom_range(KNOWN_MAX - 1)] = va;
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CLOCK_LIMIT) begin
      $display("multilevel_page_table_unit_tb failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: status %0d, frame_out %h, page_offset %h",
               status, frame_out, page_offset);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatches++;
        end
        if (frame_out !== want.frame) begin
          $error("frame_out: expected %h, actual %h", want.frame, frame_out);
          mismatches++;
        end
        if (page_offset !== want.addr) begin
          $error("page_offset: expected %h, actual %h", want.addr, page_offset);
          mismatches++;
        end
      end
    end
  end

  initial begin
    phase_t                ph;
    opcode_e               op;
    logic [ADDR_BITS-1:0]  va;
    logic [FRAME_BITS-1:0] fr;
    for (int i = 0; i < SLOTS; i++) begin
      entry_mem[i] = '0;
    end
    free_node = 7'd1;
    levels_raw = 3'd3;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      bits_raw[i] = 3'd6;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    apply_setting(phase_tbl[0]);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_request(walk_rows[r].op, walk_rows[r].addr, walk_rows[r].frame,
                   walk_rows[r].typed, walk_rows[r].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = phase_tbl[p];
      in_valid <= 1'b0;
      do @(posedge clk_i); while (pending_results.size() != 0);
      apply_setting(ph);
      send_idle_pct = ph.send_idle;
      recv_stall_pct = ph.recv_stall;
      for (int i = 0; i < ph.items; i++) begin
        if (i == ph.items / 2 && ph.hold) begin
          hold_req = 1'b1;
        end
        if (i == ph.items / 2 && ph.drain) begin
          in_valid <= 1'b0;
          do @(posedge clk_i); while (pending_results.size() != 0);
        end
        op = opcode_e'($urandom_range(1));
        fr = ($urandom_range(3) == 0) ? FRAME_BITS'($urandom_range(NODE_COUNT - 1))
                                      : FRAME_BITS'($urandom);
        va = pick_address(ph.fresh_pct);
        send_request(op, va, fr, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("multilevel_page_table_unit_tb passed");
    end else begin
      $display("multilevel_page_table_unit_tb failed");
    end
    $finish;
  end

endmodule
